@@ hdl/fams_pkg.sv @@
// ----------------------------------------------------------------------------
// fams_pkg
// Shared types and constants for the fall and motion power scene block.
// ----------------------------------------------------------------------------
package fams_pkg;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FREE  = 2'd1,
    PH_ALERT = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    REG_GATE_L1    = 3'd0,
    REG_FREE_FALL  = 3'd1,
    REG_IMPACT     = 3'd2,
    REG_WINDOW     = 3'd3,
    REG_HOLD       = 3'd4,
    REG_STEP       = 3'd5,
    REG_STILL      = 3'd6,
    REG_BOOT       = 3'd7
  } cfg_reg_t;

  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [16:0] GATE_L1_RST    = 17'd8000;
  localparam logic [15:0] FREE_FALL_RST  = 16'd5000;
  localparam logic [15:0] IMPACT_RST     = 16'd30000;
  localparam logic [15:0] WINDOW_RST     = 16'd1000;
  localparam logic [15:0] HOLD_RST       = 16'd5000;
  localparam logic [8:0]  STEP_RST       = 9'd10;
  localparam logic [31:0] STILL_RST      = 32'd15000;
  localparam logic [31:0] BOOT_RST       = 32'd10000;
  localparam logic [31:0] FREE_FALL_SQ_RST = 32'(FREE_FALL_RST) * 32'(FREE_FALL_RST);
  localparam logic [31:0] IMPACT_SQ_RST    = 32'(IMPACT_RST) * 32'(IMPACT_RST);

  localparam logic [1:0] LEVEL_AWAKE = 2'd1;
  localparam logic [1:0] LEVEL_DOZE  = 2'd2;
  localparam logic [1:0] LEVEL_DEEP  = 2'd3;
  localparam logic [1:0] MOTION_SAT  = 2'd3;
  localparam logic [1:0] MOTION_WAKE = 2'd2;

  // Thresholds as the core sees them; magnitudes are held squared.
  typedef struct packed {
    logic [16:0] gate_l1_sum;
    logic [31:0] free_fall_sq;
    logic [31:0] impact_sq;
    logic [15:0] impact_window_ms;
    logic [15:0] alert_hold_ms;
    logic [8:0]  motion_step_deg;
    logic [31:0] still_timeout_ms;
    logic [31:0] boot_delay_ms;
  } cfg_t;

  // Frame after the input stage: squares and L1 sum already formed.
  typedef struct packed {
    logic signed [8:0] pitch;
    logic [30:0]       sq_x;
    logic [30:0]       sq_y;
    logic [30:0]       sq_z;
    logic [16:0]       l1_sum;
    logic [31:0]       now_ms;
    logic              ready_req;
  } front_t;

endpackage

@@ hdl/fams_if.sv @@
// ----------------------------------------------------------------------------
// fams_frame_if / fams_result_if
// Valid/ready channels for sensor frames and per-frame results.
// ----------------------------------------------------------------------------
interface fams_frame_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] pitch;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic [31:0]       now_ms;
  logic              ready_req;

  modport source (output valid, pitch, accel_x, accel_y, accel_z, now_ms, ready_req,
                  input ready);
  modport sink   (input valid, pitch, accel_x, accel_y, accel_z, now_ms, ready_req,
                  output ready);
endinterface

interface fams_result_if;
  logic       valid;
  logic       ready;
  logic       help_alert;
  logic [1:0] power_level;
  logic       level_written;
  logic       user_activity;

  modport source (output valid, help_alert, power_level, level_written, user_activity,
                  input ready);
  modport sink   (input valid, help_alert, power_level, level_written, user_activity,
                  output ready);
endinterface

@@ hdl/fams_cfg.sv @@
// ----------------------------------------------------------------------------
// fams_cfg
// Threshold registers; magnitude levels are squared on write.
// ----------------------------------------------------------------------------
module fams_cfg
  import fams_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic [15:0] lvl_in;
  logic [31:0] lvl_sq;

  assign lvl_in = cfg_data[15:0];
  assign lvl_sq = 32'(lvl_in) * 32'(lvl_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gate_l1_sum      <= GATE_L1_RST;
      cfg.free_fall_sq     <= FREE_FALL_SQ_RST;
      cfg.impact_sq        <= IMPACT_SQ_RST;
      cfg.impact_window_ms <= WINDOW_RST;
      cfg.alert_hold_ms    <= HOLD_RST;
      cfg.motion_step_deg  <= STEP_RST;
      cfg.still_timeout_ms <= STILL_RST;
      cfg.boot_delay_ms    <= BOOT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GATE_L1:   cfg.gate_l1_sum      <= cfg_data[16:0];
        REG_FREE_FALL: cfg.free_fall_sq     <= lvl_sq;
        REG_IMPACT:    cfg.impact_sq        <= lvl_sq;
        REG_WINDOW:    cfg.impact_window_ms <= cfg_data[15:0];
        REG_HOLD:      cfg.alert_hold_ms    <= cfg_data[15:0];
        REG_STEP:      cfg.motion_step_deg  <= cfg_data[8:0];
        REG_STILL:     cfg.still_timeout_ms <= cfg_data;
        REG_BOOT:      cfg.boot_delay_ms    <= cfg_data;
        default:       ;
      endcase
    end
  end

endmodule

@@ hdl/fams_front.sv @@
// ----------------------------------------------------------------------------
// fams_front
// Input register: captures a frame with its axis squares and L1 sum.
// ----------------------------------------------------------------------------
module fams_front
  import fams_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  fams_frame_if.sink   frame,
  input  logic         take,
  output logic         stage_valid,
  output front_t       stage
);

  logic signed [16:0] ex, ey, ez;
  logic [16:0]        abs_x, abs_y, abs_z;
  logic signed [31:0] px, py, pz;

  assign ex = {frame.accel_x[15], frame.accel_x};
  assign ey = {frame.accel_y[15], frame.accel_y};
  assign ez = {frame.accel_z[15], frame.accel_z};
  assign abs_x = ex[16] ? 17'(-ex) : 17'(ex);
  assign abs_y = ey[16] ? 17'(-ey) : 17'(ey);
  assign abs_z = ez[16] ? 17'(-ez) : 17'(ez);

  assign px = 32'(frame.accel_x) * 32'(frame.accel_x);
  assign py = 32'(frame.accel_y) * 32'(frame.accel_y);
  assign pz = 32'(frame.accel_z) * 32'(frame.accel_z);

  // Refill whenever the held frame leaves or the stage is empty.
  assign frame.ready = !stage_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (frame.ready) begin
      stage_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.ready && frame.valid) begin
      stage.pitch     <= frame.pitch;
      stage.sq_x      <= px[30:0];
      stage.sq_y      <= py[30:0];
      stage.sq_z      <= pz[30:0];
      stage.l1_sum    <= abs_x + abs_y + abs_z;
      stage.now_ms    <= frame.now_ms;
      stage.ready_req <= frame.ready_req;
    end
  end

endmodule

@@ hdl/fams_core.sv @@
// ----------------------------------------------------------------------------
// fams_core
// Fall phase machine, motion wake and auto sleep; drives the result register.
// ----------------------------------------------------------------------------
module fams_core
  import fams_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          stage_valid,
  input  front_t        stage,
  output logic          take,
  fams_result_if.source result
);

  // State
  phase_t            phase, phase_next;
  logic [31:0]       fall_start, fall_start_next;
  logic signed [8:0] prev_pitch;
  logic [1:0]        motion_frames, motion_frames_next;
  logic [31:0]       still_since, still_since_next;
  logic              still_valid, still_valid_next;
  logic [31:0]       first_time, first_time_next;
  logic              first_valid, first_valid_next;
  logic              sleep_off, sleep_off_next;
  logic [1:0]        level, level_next;

  logic              fire;
  logic              gate;
  logic [31:0]       sq_sum;
  logic              below_ff, above_im;
  phase_t            phase_entry;
  logic [31:0]       fall_el;
  logic              alert;
  logic signed [9:0] pitch_diff;
  logic [9:0]        pitch_swing;
  logic              moving;
  logic [31:0]       boot_el, still_el;
  logic              written, activity;

  assign take = !result.valid || result.ready;
  assign fire = stage_valid && take;

  assign gate     = stage.l1_sum > cfg.gate_l1_sum;
  assign sq_sum   = 32'(stage.sq_x) + 32'(stage.sq_y) + 32'(stage.sq_z);
  assign below_ff = sq_sum < cfg.free_fall_sq;
  assign above_im = sq_sum > cfg.impact_sq;

  // Phase as seen after a possible free-fall entry on this frame.
  assign phase_entry = (gate && phase == PH_IDLE && below_ff) ? PH_FREE : phase;
  assign fall_start_next = (gate && phase == PH_IDLE && below_ff) ? stage.now_ms : fall_start;
  assign fall_el = stage.now_ms - fall_start_next;

  // Next phase
  always_comb begin
    phase_next = phase_entry;
    if (gate) begin
      if (phase_entry == PH_FREE) begin
        if (above_im) begin
          phase_next = PH_ALERT;
        end else if (fall_el > 32'(cfg.impact_window_ms)) begin
          phase_next = PH_IDLE;
        end
      end
      if (phase_next == PH_ALERT && fall_el > 32'(cfg.alert_hold_ms)) begin
        phase_next = PH_IDLE;
      end
    end
  end

  // Phase outputs
  always_comb begin
    alert = gate && phase_entry == PH_FREE && above_im;
  end

  assign pitch_diff  = 10'(stage.pitch) - 10'(prev_pitch);
  assign pitch_swing = pitch_diff[9] ? 10'(-pitch_diff) : 10'(pitch_diff);
  assign moving      = pitch_swing > {1'b0, cfg.motion_step_deg};

  always_comb begin
    motion_frames_next = motion_frames;
    sleep_off_next     = sleep_off;
    level_next         = level;
    still_valid_next   = still_valid;
    still_since_next   = still_since;
    first_valid_next   = first_valid;
    first_time_next    = first_time;
    written            = 1'b0;
    activity           = 1'b0;
    boot_el            = '0;
    still_el           = '0;

    if (moving) begin
      motion_frames_next = (motion_frames == MOTION_SAT) ? motion_frames
                                                         : motion_frames + 2'd1;
      if (motion_frames_next >= MOTION_WAKE) begin
        if (level != LEVEL_AWAKE) begin
          sleep_off_next = 1'b1;
        end
        level_next       = LEVEL_AWAKE;
        written          = 1'b1;
        activity         = 1'b1;
        still_valid_next = 1'b0;
      end
    end else begin
      motion_frames_next = '0;
    end

    if (!first_valid) begin
      first_time_next  = stage.now_ms;
      first_valid_next = 1'b1;
    end
    boot_el = stage.now_ms - first_time_next;

    if (stage.ready_req && !sleep_off_next && boot_el > cfg.boot_delay_ms) begin
      if (moving) begin
        still_valid_next = 1'b0;
      end else begin
        if (!still_valid_next) begin
          still_since_next = stage.now_ms;
          still_valid_next = 1'b1;
        end
        still_el = stage.now_ms - still_since_next;
        if (level_next == LEVEL_AWAKE && still_el > cfg.still_timeout_ms) begin
          level_next       = LEVEL_DOZE;
          written          = 1'b1;
          still_since_next = stage.now_ms;
        end else if (level_next == LEVEL_DOZE && still_el > cfg.still_timeout_ms) begin
          level_next = LEVEL_DEEP;
          written    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      fall_start    <= '0;
      prev_pitch    <= '0;
      motion_frames <= '0;
      still_since   <= '0;
      still_valid   <= 1'b0;
      first_time    <= '0;
      first_valid   <= 1'b0;
      sleep_off     <= 1'b0;
      level         <= LEVEL_AWAKE;
    end else if (fire) begin
      phase         <= phase_next;
      fall_start    <= fall_start_next;
      prev_pitch    <= stage.pitch;
      motion_frames <= motion_frames_next;
      still_since   <= still_since_next;
      still_valid   <= still_valid_next;
      first_time    <= first_time_next;
      first_valid   <= first_valid_next;
      sleep_off     <= sleep_off_next;
      level         <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (take) begin
      result.valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.help_alert    <= alert;
      result.power_level   <= level_next;
      result.level_written <= written;
      result.user_activity <= activity;
    end
  end

  // An alert leaves the machine in the alerted phase unless the hold already ran out.
  a_alert_phase: assert property (@(posedge clk) disable iff (rst)
    fire && alert && !(fall_el > 32'(cfg.alert_hold_ms)) |=> phase == PH_ALERT)
    else $error("alert raised without entering alerted phase");

  a_wake_level: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.user_activity |->
      result.power_level == LEVEL_AWAKE && result.level_written)
    else $error("motion wake without level set to awake");

  a_level_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(level) && $stable(phase))
    else $error("state moved without a frame");

  a_level_written: assert property (@(posedge clk) disable iff (rst)
    fire && level_next != level |-> written)
    else $error("level changed without a level set");

endmodule

@@ hdl/fall_and_motion_power_scene.sv @@
// ----------------------------------------------------------------------------
// fall_and_motion_power_scene
// Per-frame fall detection, motion wake and stillness-driven power levels.
// ----------------------------------------------------------------------------
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+-------------------------------------
//   frame    | in  | valid/ready        | pitch, accel_x/y/z, now_ms, ready_req
//   result   | out | valid/ready        | help_alert, power_level,
//            |     |                    | level_written, user_activity
//   cfg      | in  | cfg_we (no ready)  | cfg_index, cfg_data
//
// One frame per cycle sustained while results are taken; an accepted frame
// passes through the input register (squares and L1 sum), then the state update
// into the result register, where result.valid is set.
// The state is updated once per frame.
// Synchronous active-high reset clears the valid flags and all core state and loads default thresholds.
// A stalled result holds; the input register still takes a frame while the
// held result waits, then frame.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module fall_and_motion_power_scene
  import fams_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  fams_frame_if.sink            frame,
  fams_result_if.source         result,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg;
  front_t stage;
  logic   stage_valid;
  logic   take;

  fams_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fams_front u_front (
    .clk         (clk),
    .rst         (rst),
    .frame       (frame),
    .take        (take),
    .stage_valid (stage_valid),
    .stage       (stage)
  );

  fams_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .stage_valid (stage_valid),
    .stage       (stage),
    .take        (take),
    .result      (result)
  );

endmodule
